// ----- hdl/lgfs_pkg.sv -----
// Shared types and constants of the lidar gap-follow steering block.
package lgfs_pkg;

	localparam int ANGLE_LIMIT = 3294199;
	localparam int IDX_REG_W   = 3;
	localparam int CFG_DATA_W  = 23;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [IDX_REG_W-1:0] REG_OBSTACLE_DISTANCE = 3'd0;
	localparam logic [IDX_REG_W-1:0] REG_ANGLE_START       = 3'd1;
	localparam logic [IDX_REG_W-1:0] REG_ANGLE_STEP        = 3'd2;
	localparam logic [IDX_REG_W-1:0] REG_STEER_GAIN        = 3'd3;
	localparam logic [IDX_REG_W-1:0] REG_SPEED_TURNING     = 3'd4;
	localparam logic [IDX_REG_W-1:0] REG_SPEED_CRUISE      = 3'd5;
	localparam logic [IDX_REG_W-1:0] REG_TURN_THRESHOLD    = 3'd6;

	localparam logic        [15:0] RST_OBSTACLE_DISTANCE = 16'd1200;
	localparam logic signed [22:0] RST_ANGLE_START       = -23'sd2464153;
	localparam logic        [15:0] RST_ANGLE_STEP        = 16'd4508;
	localparam logic        [15:0] RST_STEER_GAIN        = 16'd2908;
	localparam logic        [15:0] RST_SPEED_TURNING     = 16'd1500;
	localparam logic        [15:0] RST_SPEED_CRUISE      = 16'd3000;
	localparam logic        [21:0] RST_TURN_THRESHOLD    = 22'd183011;

	typedef struct packed {
		logic        [15:0] obstacle_distance;
		logic signed [22:0] angle_start;
		logic        [15:0] angle_step;
		logic        [15:0] steer_gain;
		logic        [15:0] speed_turning;
		logic        [15:0] speed_cruise;
		logic        [21:0] turn_threshold;
	} cfg_t;

endpackage

// ----- hdl/lgfs_if.sv -----
// Valid/ready channel interfaces for lidar samples and steering results.
interface lgfs_sample_if;
	logic        valid;
	logic        ready;
	logic [15:0] range_mm;
	logic        sample_invalid;
	logic        last_sample;

	modport source (output valid, range_mm, sample_invalid, last_sample, input ready);
	modport sink   (input valid, range_mm, sample_invalid, last_sample, output ready);
	modport monitor(input valid, ready, range_mm, sample_invalid, last_sample);
endinterface

interface lgfs_result_if;
	logic               valid;
	logic               ready;
	logic signed [22:0] steer_angle;
	logic        [15:0] drive_speed;
	logic        [11:0] gap_length;
	logic        [10:0] gap_first;
	logic signed [22:0] gap_angle;

	modport source (output valid, steer_angle, drive_speed, gap_length, gap_first, gap_angle,
		input ready);
	modport sink   (input valid, steer_angle, drive_speed, gap_length, gap_first, gap_angle,
		output ready);
	modport monitor(input valid, ready, steer_angle, drive_speed, gap_length, gap_first,
		gap_angle);
endinterface

// ----- hdl/lgfs_front.sv -----
// Front end: tracks free runs over the sample stream and queues one gap per scan.
module lgfs_front #(
	parameter int MAX_SAMPLES = 2048,
	parameter int IDX_W       = $clog2(MAX_SAMPLES),
	parameter int LEN_W       = $clog2(MAX_SAMPLES + 1)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  lgfs_pkg::cfg_t         cfg,
	lgfs_sample_if.sink            samples,
	output logic                   push_valid,
	input  logic                   push_ready,
	output logic [IDX_W+LEN_W-1:0] push_data
);

	localparam int D_W = LEN_W + 2;

	logic [IDX_W-1:0] idx_q;
	logic [LEN_W-1:0] run_q, best_len_q;
	logic [IDX_W-1:0] best_first_q;

	logic [LEN_W-1:0] run_a, best_len_a, best_len_f;
	logic [IDX_W-1:0] best_first_a, best_first_f;
	logic             accept;

	// Start of a run ending at end_i, modulo MAX_SAMPLES.
	function automatic logic [IDX_W-1:0] start_of(input logic [IDX_W:0] end_i,
		input logic [LEN_W-1:0] len);
		logic signed [D_W-1:0] d;
		d = $signed(D_W'(end_i)) - $signed(D_W'(len));
		if (d < 0) begin
			d = d + $signed(D_W'(MAX_SAMPLES));
		end else if (d >= $signed(D_W'(MAX_SAMPLES))) begin
			d = d - $signed(D_W'(MAX_SAMPLES));
		end
		return d[IDX_W-1:0];
	endfunction

	assign samples.ready = push_ready;
	assign accept        = samples.valid && push_ready;

	always_comb begin
		run_a        = run_q;
		best_len_a   = best_len_q;
		best_first_a = best_first_q;
		if (!samples.sample_invalid) begin
			if (samples.range_mm < cfg.obstacle_distance) begin
				if (run_q > best_len_q) begin
					best_len_a   = run_q;
					best_first_a = start_of({1'b0, idx_q}, run_q);
				end
				run_a = '0;
			end else if (run_q < LEN_W'(MAX_SAMPLES)) begin
				run_a = run_q + 1'b1;
			end
		end
		// close any run still open at the end of the scan
		best_len_f   = best_len_a;
		best_first_f = best_first_a;
		if (run_a > best_len_a) begin
			best_len_f   = run_a;
			best_first_f = start_of({1'b0, idx_q} + 1'b1, run_a);
		end
	end

	assign push_valid = accept && samples.last_sample;
	assign push_data  = {best_first_f, best_len_f};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q        <= '0;
			run_q        <= '0;
			best_len_q   <= '0;
			best_first_q <= '0;
		end else if (accept) begin
			if (samples.last_sample) begin
				idx_q        <= '0;
				run_q        <= '0;
				best_len_q   <= '0;
				best_first_q <= '0;
			end else begin
				idx_q        <= (idx_q == IDX_W'(MAX_SAMPLES - 1)) ? '0 : idx_q + 1'b1;
				run_q        <= run_a;
				best_len_q   <= best_len_a;
				best_first_q <= best_first_a;
			end
		end
	end

endmodule

// ----- hdl/lgfs_queue.sv -----
// Small register queue between the front end and the steering back end.
module lgfs_queue #(
	parameter int WIDTH = 23,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output logic [WIDTH-1:0] pop_data
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push, do_pop;

	assign push_ready = (count_q != CW'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- hdl/lgfs_back.sv -----
// Back end: turns a queued gap into heading, steering and speed.
module lgfs_back #(
	parameter int IDX_W = 11,
	parameter int LEN_W = 12
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  lgfs_pkg::cfg_t         cfg,
	input  logic                   job_valid,
	output logic                   job_ready,
	input  logic [IDX_W+LEN_W-1:0] job_data,
	lgfs_result_if.source          results
);

	localparam int SPAN_W = LEN_W + 2;
	localparam int PROD_W = SPAN_W + 16;
	localparam int HALF_W = PROD_W - 1;
	localparam int SUM_W  = ((HALF_W > 23) ? HALF_W : 23) + 2;

	localparam logic signed [SUM_W-1:0] LIM_SUM = SUM_W'(lgfs_pkg::ANGLE_LIMIT);
	localparam logic signed [39:0]      LIM_STR = 40'(lgfs_pkg::ANGLE_LIMIT);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_MUL   = 5'b00010,
		ST_ANGLE = 5'b00100,
		ST_STEER = 5'b01000,
		ST_OUT   = 5'b10000
	} state_t;

	state_t state_q;

	logic [LEN_W-1:0]         len_q;
	logic [IDX_W-1:0]         first_q;
	logic [SPAN_W-1:0]        span_q;
	logic [HALF_W-1:0]        half_q;
	logic signed [22:0]       ang_q;
	logic signed [39:0]       prod_q;
	logic [PROD_W-1:0]        span_prod;
	logic signed [SUM_W-1:0]  sum;
	logic signed [22:0]       ang_sat;
	logic signed [39:0]       steer_sh;
	logic signed [22:0]       steer_sat;
	logic                     out_free;
	logic                     res_valid_q;

	assign job_ready = (state_q == ST_IDLE);
	assign out_free  = !res_valid_q || results.ready;

	assign span_prod = PROD_W'(span_q) * PROD_W'(cfg.angle_step);

	always_comb begin
		sum = SUM_W'($signed(cfg.angle_start)) + SUM_W'(half_q);
		if (sum > LIM_SUM) begin
			ang_sat = 23'(LIM_SUM);
		end else if (sum < -LIM_SUM) begin
			ang_sat = 23'(-LIM_SUM);
		end else begin
			ang_sat = sum[22:0];
		end
		// arithmetic shift gives floor division by 4096
		steer_sh = prod_q >>> 12;
		if (steer_sh > LIM_STR) begin
			steer_sat = 23'(LIM_STR);
		end else if (steer_sh < -LIM_STR) begin
			steer_sat = 23'(-LIM_STR);
		end else begin
			steer_sat = steer_sh[22:0];
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (job_valid) begin
					{first_q, len_q} <= job_data;
					span_q <= SPAN_W'({job_data[IDX_W+LEN_W-1:LEN_W], 1'b0})
						+ SPAN_W'(job_data[LEN_W-1:0]);
				end
			end
			ST_MUL:   half_q <= span_prod[PROD_W-1:1];
			ST_ANGLE: ang_q  <= ang_sat;
			ST_STEER: prod_q <= $signed({1'b0, cfg.steer_gain}) * ang_q;
			ST_OUT: begin
				if (out_free) begin
					results.steer_angle <= steer_sat;
					results.drive_speed <= (ang_q > $signed({1'b0, cfg.turn_threshold}))
						? cfg.speed_turning : cfg.speed_cruise;
					results.gap_length  <= 12'(len_q);
					results.gap_first   <= 11'(first_q);
					results.gap_angle   <= ang_q;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE:  if (job_valid) state_q <= ST_MUL;
				ST_MUL:   state_q <= ST_ANGLE;
				ST_ANGLE: state_q <= ST_STEER;
				ST_STEER: state_q <= ST_OUT;
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			// load a new result, or drop the old one once it is taken
			if ((state_q == ST_OUT) && out_free) begin
				res_valid_q <= 1'b1;
			end else if (results.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign results.valid = res_valid_q;

endmodule

// ----- hdl/lidar_gap_follow_steer_top.sv -----
// Top level of the lidar gap-follow steering block.
// Usage: stream one lidar range sample per transfer on the samples channel
// (range_mm, sample_invalid, last_sample). Each valid sample below
// obstacle_distance ends the current free run; the longest run of the scan
// is kept, the earlier one on a tie. Invalid samples only advance the index.
// The transfer flagged last_sample ends the scan and yields exactly one
// result transfer on the results channel: mid-gap angle, steering command,
// speed, and the gap's first index and length.
// Throughput: one sample per cycle while the queue is not full; the front end
// clears its run state on the last sample, so the next scan may start in the
// very next cycle. The last sample's transfer pushes its gap into the queue.
// The back end takes one gap at a time (capture span, multiply by angle_step,
// saturating add, multiply by steer_gain, shift into the output register).
// Up to two finished scans wait in the queue between the two ends; when it
// is full, samples.ready drops until the back end takes one.
// A stalled result holds in the output register; the back end finishes the
// next scan and then waits.
// Reset: arst_n clears the run state, the queue and the back end and loads the
// register defaults. Write registers through cfg_wen/cfg_index/cfg_data only
// while no scan is in flight.
module lidar_gap_follow_steer_top #(
	parameter int MAX_SAMPLES = 2048
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wen,
	input  logic [lgfs_pkg::IDX_REG_W-1:0]  cfg_index,
	input  logic [lgfs_pkg::CFG_DATA_W-1:0] cfg_data,
	lgfs_sample_if.sink                     samples,
	lgfs_result_if.source                   results
);

	localparam int IDX_W = $clog2(MAX_SAMPLES);
	localparam int LEN_W = $clog2(MAX_SAMPLES + 1);
	localparam int JOB_W = IDX_W + LEN_W;

	lgfs_pkg::cfg_t cfg_q;

	logic             push_valid, push_ready;
	logic [JOB_W-1:0] push_data;
	logic             job_valid, job_ready;
	logic [JOB_W-1:0] job_data;

	// Register file: write-only, indexes past the list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.obstacle_distance <= lgfs_pkg::RST_OBSTACLE_DISTANCE;
			cfg_q.angle_start       <= lgfs_pkg::RST_ANGLE_START;
			cfg_q.angle_step        <= lgfs_pkg::RST_ANGLE_STEP;
			cfg_q.steer_gain        <= lgfs_pkg::RST_STEER_GAIN;
			cfg_q.speed_turning     <= lgfs_pkg::RST_SPEED_TURNING;
			cfg_q.speed_cruise      <= lgfs_pkg::RST_SPEED_CRUISE;
			cfg_q.turn_threshold    <= lgfs_pkg::RST_TURN_THRESHOLD;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				lgfs_pkg::REG_OBSTACLE_DISTANCE: cfg_q.obstacle_distance <= cfg_data[15:0];
				lgfs_pkg::REG_ANGLE_START:       cfg_q.angle_start       <= cfg_data[22:0];
				lgfs_pkg::REG_ANGLE_STEP:        cfg_q.angle_step        <= cfg_data[15:0];
				lgfs_pkg::REG_STEER_GAIN:        cfg_q.steer_gain        <= cfg_data[15:0];
				lgfs_pkg::REG_SPEED_TURNING:     cfg_q.speed_turning     <= cfg_data[15:0];
				lgfs_pkg::REG_SPEED_CRUISE:      cfg_q.speed_cruise      <= cfg_data[15:0];
				lgfs_pkg::REG_TURN_THRESHOLD:    cfg_q.turn_threshold    <= cfg_data[21:0];
				default: ;
			endcase
		end
	end

	// Front end: run tracking at one sample per cycle while the queue has room.
	lgfs_front #(
		.MAX_SAMPLES(MAX_SAMPLES),
		.IDX_W      (IDX_W),
		.LEN_W      (LEN_W)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.samples   (samples),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data (push_data)
	);

	// Hold finished gaps until the back end is free.
	lgfs_queue #(
		.WIDTH(JOB_W),
		.DEPTH(lgfs_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data (push_data),
		.pop_valid (job_valid),
		.pop_ready (job_ready),
		.pop_data  (job_data)
	);

	// Back end: per-scan arithmetic and the result register.
	lgfs_back #(
		.IDX_W(IDX_W),
		.LEN_W(LEN_W)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.job_valid(job_valid),
		.job_ready(job_ready),
		.job_data (job_data),
		.results  (results)
	);

endmodule

// ----- hdl/lgfs_checker.sv -----
// Port-level checks of the gap-follow steering block, bound to its top level.
module lgfs_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               sample_valid,
	input logic               sample_ready,
	input logic               sample_last,
	input logic               result_valid,
	input logic               result_ready,
	input logic signed [22:0] steer_angle,
	input logic        [15:0] drive_speed,
	input logic        [11:0] gap_length,
	input logic        [10:0] gap_first,
	input logic signed [22:0] gap_angle
);

	localparam logic signed [22:0] LIM = 23'(lgfs_pkg::ANGLE_LIMIT);

	logic [2:0] pend_q;
	logic       scan_end, res_xfer;

	assign scan_end = sample_valid && sample_ready && sample_last;
	assign res_xfer = result_valid && result_ready;

	// Count scans ended but not yet answered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (scan_end && !res_xfer) begin
			pend_q <= pend_q + 1'b1;
		end else if (res_xfer && !scan_end) begin
			pend_q <= pend_q - 1'b1;
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(steer_angle)
		&& $stable(gap_angle) && $stable(drive_speed) && $stable(gap_length)
		&& $stable(gap_first))
		else $error("stalled result changed");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> pend_q != 3'd0)
		else $error("result without a finished scan");

	a_capacity: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= 3'd4)
		else $error("more scans in flight than the block can hold");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> gap_angle <= LIM && gap_angle >= -LIM
		&& steer_angle <= LIM && steer_angle >= -LIM)
		else $error("angle outside saturation limit");

endmodule

bind lidar_gap_follow_steer_top lgfs_checker u_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.sample_valid(samples.valid),
	.sample_ready(samples.ready),
	.sample_last (samples.last_sample),
	.result_valid(results.valid),
	.result_ready(results.ready),
	.steer_angle (results.steer_angle),
	.drive_speed (results.drive_speed),
	.gap_length  (results.gap_length),
	.gap_first   (results.gap_first),
	.gap_angle   (results.gap_angle)
);
